// ===== rtl/crcm_pkg.sv =====
// Package for the contiguous ring chunk manager.
// Holds the opcode and status codes and the ring size constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crcm_pkg;

  localparam int unsigned RingBytes = 65536;
  localparam int unsigned SizeLimit = 65536;
  localparam int unsigned LenW      = 17;
  localparam int unsigned OffW      = 16;
  localparam int unsigned OutstW    = 18;

  typedef enum logic [1:0] {
    OpReserve = 2'd0,
    OpCommit  = 2'd1,
    OpRead    = 2'd2,
    OpFree    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadArg = 2'd1,
    StSize   = 2'd2,
    StNoMem  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/contiguous_ring_chunk_manager_unit.sv =====
// Top level of the contiguous ring chunk manager: offset bookkeeping for a ring
// whose chunks never straddle the ring end. Depends on crcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One word is accepted per cycle: the word lands in an input register, the
// reserve, commit, read or free decision is made in one pass of compares and
// adds against the pointer registers, and the result is held in an output
// register. The pointer update of one word is visible to the next word in the
// following cycle, so the rate is one word per cycle; the input side stalls
// only while a result waits for out_ready_i.
// A write of a nonzero ring size on the cfg port clamps it to RING_BYTES and
// resets all pointers and counts; a write of zero is ignored.
module contiguous_ring_chunk_manager_unit #(
  parameter int unsigned RING_BYTES = crcm_pkg::RingBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [crcm_pkg::LenW-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [crcm_pkg::LenW-1:0]     length_i,
  input  wire logic [crcm_pkg::OffW-1:0]     offset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [crcm_pkg::OffW-1:0]          chunk_offset_o,
  output logic [crcm_pkg::LenW-1:0]          granted_length_o
);

  localparam int unsigned LenW   = crcm_pkg::LenW;
  localparam int unsigned OffW   = crcm_pkg::OffW;
  localparam int unsigned OutstW = crcm_pkg::OutstW;
  localparam int unsigned SizeReset =
    (RING_BYTES < crcm_pkg::SizeLimit) ? RING_BYTES : crcm_pkg::SizeLimit;

  // input register
  logic                in_valid_q;
  crcm_pkg::op_e       op_q;
  logic [LenW-1:0]     len_q;
  logic [OffW-1:0]     off_q;

  // result register
  logic                out_valid_q;
  crcm_pkg::status_e   status_q, status_d;
  logic [OffW-1:0]     chunk_q, chunk_d;
  logic [LenW-1:0]     granted_q, granted_d;

  // ring state
  logic [LenW-1:0]     size_q;
  logic [LenW-1:0]     write_pos_q, write_pos_d;
  logic [LenW-1:0]     release_pos_q, release_pos_d;
  logic [LenW-1:0]     read_cursor_q, read_cursor_d;
  logic [LenW-1:0]     eod_q, eod_d;
  logic                eod_valid_q, eod_valid_d;
  logic [LenW-1:0]     readable_q, readable_d;
  logic [OutstW-1:0]   outstanding_q, outstanding_d;

  logic                advance;
  logic                cfg_take;
  logic [LenW-1:0]     cfg_size;

  logic [LenW-1:0]     room;
  logic                busy;
  logic [LenW:0]       wr_end;
  logic [LenW:0]       commit_sum;
  logic [LenW:0]       rc_end;
  logic [LenW-1:0]     cur;
  logic [LenW:0]       cur_end;
  logic [LenW-1:0]     rem;
  logic [LenW-1:0]     grant_len;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  assign cfg_take = cfg_we_i && (cfg_wdata_i != '0);
  assign cfg_size = (32'(cfg_wdata_i) > 32'(RING_BYTES)) ? LenW'(RING_BYTES) : cfg_wdata_i;

  assign room   = (size_q > write_pos_q) ? size_q - write_pos_q : '0;
  assign busy   = (write_pos_q == release_pos_q) && (outstanding_q != '0)
                  && !outstanding_q[OutstW-1];
  assign wr_end = {1'b0, write_pos_q} + {1'b0, len_q};
  assign commit_sum = {1'b0, readable_q} + {1'b0, len_q};
  assign rc_end = {1'b0, read_cursor_q} + {1'b0, len_q};
  assign cur    = (rc_end > {1'b0, size_q}) ? '0 : read_cursor_q;
  assign cur_end = {1'b0, cur} + {1'b0, len_q};
  assign rem    = (eod_q > cur) ? eod_q - cur : '0;

  always_comb begin
    status_d      = crcm_pkg::StOk;
    chunk_d       = '0;
    granted_d     = '0;
    grant_len     = '0;
    write_pos_d   = write_pos_q;
    release_pos_d = release_pos_q;
    read_cursor_d = read_cursor_q;
    eod_d         = eod_q;
    eod_valid_d   = eod_valid_q;
    readable_d    = readable_q;
    outstanding_d = outstanding_q;
    unique case (op_q)
      crcm_pkg::OpReserve: begin
        if (len_q > size_q) begin
          status_d = crcm_pkg::StSize;
        end else if (len_q <= room) begin
          if (((write_pos_q < release_pos_q) && (wr_end > {1'b0, release_pos_q})) || busy) begin
            status_d = crcm_pkg::StNoMem;
          end else begin
            chunk_d     = write_pos_q[OffW-1:0];
            write_pos_d = wr_end[LenW-1:0];
          end
        end else begin
          if ((release_pos_q < len_q) || (release_pos_q > write_pos_q) || busy) begin
            status_d = crcm_pkg::StNoMem;
          end else begin
            eod_d       = write_pos_q;
            eod_valid_d = 1'b1;
            write_pos_d = len_q;
          end
        end
        if (status_d == crcm_pkg::StOk) begin
          outstanding_d = outstanding_q + {1'b0, len_q};
        end
      end
      crcm_pkg::OpCommit: begin
        readable_d = commit_sum[LenW] ? '1 : commit_sum[LenW-1:0];
      end
      crcm_pkg::OpRead: begin
        if (len_q > size_q) begin
          status_d = crcm_pkg::StBadArg;
        end else if (len_q > readable_q) begin
          status_d = crcm_pkg::StNoMem;
        end else begin
          if (eod_valid_q && (cur_end > {1'b0, eod_q})) begin
            if (rem == '0) begin
              grant_len     = len_q;
              read_cursor_d = len_q;
            end else begin
              grant_len     = rem;
              chunk_d       = cur[OffW-1:0];
              read_cursor_d = '0;
            end
            eod_valid_d = 1'b0;
          end else begin
            grant_len     = len_q;
            chunk_d       = cur[OffW-1:0];
            read_cursor_d = cur_end[LenW-1:0];
          end
          granted_d  = grant_len;
          readable_d = (readable_q > grant_len) ? readable_q - grant_len : '0;
        end
      end
      crcm_pkg::OpFree: begin
        release_pos_d = LenW'({1'b0, off_q} + len_q);
        outstanding_d = outstanding_q - {1'b0, len_q};
      end
      default: begin
        status_d = crcm_pkg::StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= crcm_pkg::op_e'(opcode_i);
      len_q <= length_i;
      off_q <= offset_i;
    end
    if (advance && in_valid_q) begin
      status_q  <= status_d;
      chunk_q   <= chunk_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q        <= LenW'(SizeReset);
      write_pos_q   <= '0;
      release_pos_q <= '0;
      read_cursor_q <= '0;
      eod_q         <= '0;
      eod_valid_q   <= 1'b0;
      readable_q    <= '0;
      outstanding_q <= '0;
    end else if (cfg_take) begin
      size_q        <= cfg_size;
      write_pos_q   <= '0;
      release_pos_q <= '0;
      read_cursor_q <= '0;
      eod_q         <= '0;
      eod_valid_q   <= 1'b0;
      readable_q    <= '0;
      outstanding_q <= '0;
    end else if (advance && in_valid_q) begin
      write_pos_q   <= write_pos_d;
      release_pos_q <= release_pos_d;
      read_cursor_q <= read_cursor_d;
      eod_q         <= eod_d;
      eod_valid_q   <= eod_valid_d;
      readable_q    <= readable_d;
      outstanding_q <= outstanding_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign chunk_offset_o   = chunk_q;
  assign granted_length_o = granted_q;

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q != '0)
    else $error("ring size register is zero");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_take |=> (write_pos_q == '0) && !eod_valid_q && (outstanding_q == '0))
    else $error("ring size write did not clear state");

  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("input word lost between stages");

  a_refusal_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != crcm_pkg::StOk) |-> (chunk_q == '0) && (granted_q == '0))
    else $error("refused request carries a chunk");

  a_grant_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && (granted_d != '0) |-> (op_q == crcm_pkg::OpRead))
    else $error("length granted by a non-read word");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for contiguous_ring_chunk_manager_unit: directed and random words checked
// against an in-bench offset tracker under random idling on both sides.
// Depends on crcm_pkg and the RTL top level only.
`timescale 1ns / 1ps

import crcm_pkg::*;

typedef struct packed {
  status_e     status;
  logic [15:0] chunk;
  logic [16:0] granted;
} ring_result_t;

class ring_offset_tracker;
  ring_result_t pending_results[$];
  ring_result_t last;
  int unsigned  errors;
  bit [16:0]    ring_size;
  bit [16:0]    wr_pos;
  bit [16:0]    rel_pos;
  bit [16:0]    rd_cursor;
  bit [16:0]    eod_pos;
  bit           eod_mark;
  bit [16:0]    readable;
  bit [17:0]    outstanding;

  function new();
    ring_size = 17'(RingBytes);
    errors    = 0;
    clear();
  endfunction

  function void clear();
    wr_pos      = '0;
    rel_pos     = '0;
    rd_cursor   = '0;
    eod_pos     = '0;
    eod_mark    = 1'b0;
    readable    = '0;
    outstanding = '0;
  endfunction

  function void configure(bit [16:0] value);
    if (value == 0) return;
    ring_size = (value > RingBytes) ? 17'(RingBytes) : value;
    clear();
  endfunction

  function void note_word(op_e op, bit [16:0] len, bit [15:0] off);
    int unsigned  l;
    int unsigned  wr;
    int unsigned  rd;
    int unsigned  room;
    int unsigned  cur;
    int unsigned  rem;
    bit           busy;
    ring_result_t r;
    l = len;
    wr = wr_pos;
    rd = rel_pos;
    r.status = StOk;
    r.chunk = '0;
    r.granted = '0;
    case (op)
      OpReserve: begin
        room = (ring_size > wr) ? ring_size - wr : 0;
        busy = (wr == rd) && outstanding != 0 && !outstanding[17];
        if (l > ring_size) begin
          r.status = StSize;
        end else if (l <= room) begin
          if ((wr < rd && wr + l > rd) || busy) begin
            r.status = StNoMem;
          end else begin
            r.chunk = 16'(wr);
            wr_pos = 17'(wr + l);
          end
        end else if (rd < l || rd > wr || busy) begin
          r.status = StNoMem;
        end else begin
          eod_pos = 17'(wr);
          eod_mark = 1'b1;
          wr_pos = 17'(l);
        end
        if (r.status == StOk) outstanding = outstanding + 18'(l);
      end
      OpCommit: begin
        readable = (readable + l > 17'h1FFFF) ? 17'h1FFFF : 17'(readable + l);
      end
      OpRead: begin
        if (l > ring_size) begin
          r.status = StBadArg;
        end else if (l > readable) begin
          r.status = StNoMem;
        end else begin
          cur = rd_cursor;
          if (cur + l > ring_size) cur = 0;
          if (eod_mark && cur + l > eod_pos) begin
            rem = (eod_pos > cur) ? eod_pos - cur : 0;
            if (rem == 0) begin
              r.granted = 17'(l);
              cur = l;
            end else begin
              r.granted = 17'(rem);
              r.chunk = 16'(cur);
              cur = 0;
            end
            eod_mark = 1'b0;
          end else begin
            r.granted = 17'(l);
            r.chunk = 16'(cur);
            cur = cur + l;
          end
          readable = (readable > r.granted) ? readable - r.granted : '0;
          rd_cursor = 17'(cur);
        end
      end
      OpFree: begin
        rel_pos = 17'(off + l);
        outstanding = outstanding - 18'(l);
      end
    endcase
    pending_results.push_back(r);
    last = r;
  endfunction

  function void check_result(logic [1:0] status, logic [15:0] chunk, logic [16:0] granted);
    ring_result_t exp;
    if (pending_results.size() == 0) begin
      $error("result word with no word pending");
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    if (exp.status != status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      errors++;
    end
    if (exp.chunk != chunk) begin
      $error("chunk_offset: expected %0d, got %0d", exp.chunk, chunk);
      errors++;
    end
    if (exp.granted != granted) begin
      $error("granted_length: expected %0d, got %0d", exp.granted, granted);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int StallLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = OpReserve;
  logic [16:0] length_i = '0;
  logic [15:0] offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] chunk_offset_o;
  logic [16:0] granted_length_o;

  ring_offset_tracker tracker = new();
  bit tx_idle = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold = 1'b0;
  int stall_cycles = 0;

  contiguous_ring_chunk_manager_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .length_i        (length_i),
    .offset_i        (offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .chunk_offset_o  (chunk_offset_o),
    .granted_length_o(granted_length_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stalls, one long hold on request
  always begin
    @(posedge clk_i);
    if (rx_hold) begin
      out_ready_i <= 1'b0;
      repeat (79) @(posedge clk_i);
      rx_hold = 1'b0;
    end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(0, 9)) @(posedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(status_o, chunk_offset_o, granted_length_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(op_e op, bit [16:0] len, bit [15:0] off);
    if (tx_idle && !tx_calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    length_i   <= len;
    offset_i   <= off;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(op, len, off);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(bit [16:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.configure(value);
  endtask

  function automatic bit [16:0] pick_len(bit [16:0] size);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return size;
      2:       return 17'(size + 1);
      3:       return 17'($urandom_range(0, 17'h1FFFF));
      4, 5, 6, 7, 8, 9: return 17'($urandom_range(1, size));
      default: return 17'($urandom_range(1, (size > 4) ? size / 4 : 1));
    endcase
  endfunction

  // mostly reserve/commit and read/free pairs, some random words
  task automatic run_phase(int n);
    int        k;
    bit [16:0] len;
    k = 0;
    while (k < n) begin
      if (k % 30 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      len = pick_len(tracker.ring_size);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_word(OpReserve, len, 16'($urandom));
          k++;
          if (tracker.last.status == StOk) begin
            send_word(OpCommit, len, 16'($urandom));
            k++;
          end
        end
        4, 5, 6, 7: begin
          send_word(OpRead, len, 16'($urandom));
          k++;
          if (tracker.last.status == StOk) begin
            send_word(OpFree, tracker.last.granted, tracker.last.chunk);
            k++;
          end
        end
        default: begin
          if ($urandom_range(0, 1) == 0) len = 17'($urandom);
          send_word(op_e'($urandom_range(0, 3)), len, 16'($urandom));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OpReserve, 17'd0, 16'd0);
    send_word(OpReserve, 17'd65536, 16'd0);
    send_word(OpReserve, 17'd1, 16'd0);
    send_word(OpReserve, 17'd65537, 16'hFFFF);
    send_word(OpReserve, 17'h1FFFF, 16'd0);
    send_word(OpCommit, 17'h1FFFF, 16'd0);
    send_word(OpCommit, 17'd5, 16'd0);
    send_word(OpRead, 17'd65537, 16'd0);
    send_word(OpRead, 17'd65536, 16'd0);
    send_word(OpRead, 17'd16, 16'd0);
    send_word(OpFree, 17'h1FFFF, 16'hFFFF);
    send_word(OpFree, 17'd0, 16'd0);

    write_size(17'd16);
    send_word(OpReserve, 17'd12, 16'd0);
    send_word(OpFree, 17'd12, 16'd0);
    send_word(OpCommit, 17'd40, 16'd0);
    send_word(OpRead, 17'd12, 16'd0);
    send_word(OpReserve, 17'd8, 16'd0);
    send_word(OpRead, 17'd2, 16'd0);
    send_word(OpRead, 17'd6, 16'd0);
    send_word(OpRead, 17'd17, 16'd0);
    send_word(OpReserve, 17'd17, 16'd0);
    send_word(OpRead, 17'd14, 16'd0);

    tx_idle = 1'b1;
    write_size(17'd16);
    run_phase(100);
    write_size(17'd1);
    run_phase(60);
    write_size(17'd100);
    rx_hold = 1'b1;
    run_phase(100);
    write_size(17'd1000);
    run_phase(50);
    drain();
    run_phase(50);
    write_size(17'h1FFFF);
    run_phase(80);
    write_size(17'd0);
    run_phase(60);
    write_size(17'd65536);
    run_phase(60);
    write_size(17'd4096);
    run_phase(100);

    write_size(17'd24);
    tx_idle  = 1'b0;
    rx_quiet = 1'b1;
    run_phase(100);

    drain();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
